@@ rtl/bfns_pkg.sv @@
// ----------------------------------------------------------------------------
// bfns_pkg
// Shared widths, operation codes and scan pipeline structs for the bitmap
// next-set-bit search.
// ----------------------------------------------------------------------------
package bfns_pkg;

  localparam int IDX_W  = 6;   // word index field
  localparam int DATA_W = 64;  // word data field
  localparam int POS_W  = 13;  // bit numbers, start and size
  localparam int CNT_W  = POS_W + 1;  // word counter and base, one bit of headroom
  localparam int LANE_W = 6;   // bit within a word, words up to 64 bits

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  // one word on its way from the read port into the scan stage
  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  base;
    logic              first;
    logic [LANE_W-1:0] offset;
    logic              last;
    logic [LANE_W-1:0] limit;
  } scan_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [CNT_W-1:0] pos;
  } scan_res_t;

endpackage

@@ rtl/bfns_in_if.sv @@
// ----------------------------------------------------------------------------
// bfns_in_if
// Request channel: word writes and search requests.
// ----------------------------------------------------------------------------
interface bfns_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [bfns_pkg::IDX_W-1:0]   word_index;
  logic [bfns_pkg::DATA_W-1:0]  word_data;
  logic [bfns_pkg::POS_W-1:0]   start_bit;
  logic [bfns_pkg::POS_W-1:0]   search_size;

  modport source (
    output valid, operation, word_index, word_data, start_bit, search_size,
    input  ready
  );
  modport sink (
    input  valid, operation, word_index, word_data, start_bit, search_size,
    output ready
  );
endinterface

@@ rtl/bfns_out_if.sv @@
// ----------------------------------------------------------------------------
// bfns_out_if
// Result channel: position of the next set bit.
// ----------------------------------------------------------------------------
interface bfns_out_if;
  logic                        valid;
  logic                        ready;
  logic [bfns_pkg::POS_W-1:0]  bit_position;
  logic                        found;

  modport source (output valid, bit_position, found, input ready);
  modport sink   (input  valid, bit_position, found, output ready);
endinterface

@@ rtl/bfns_ram.sv @@
// ----------------------------------------------------------------------------
// bfns_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfns_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bfns_word_scan.sv @@
// ----------------------------------------------------------------------------
// bfns_word_scan
// Masks one bitmap word to the search window and finds its lowest set bit.
// ----------------------------------------------------------------------------
module bfns_word_scan #(
  parameter int WORD_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [WORD_BITS-1:0]      data,
  input  bfns_pkg::scan_ctl_t       ctl,
  output bfns_pkg::scan_res_t       res
);

  logic [WORD_BITS-1:0]        lo_mask;
  logic [WORD_BITS-1:0]        hi_mask;
  logic [WORD_BITS-1:0]        masked;
  logic [WORD_BITS-1:0]        isolated;
  logic [bfns_pkg::LANE_W-1:0] lane;

  assign lo_mask  = ctl.first ? ({WORD_BITS{1'b1}} << ctl.offset) : {WORD_BITS{1'b1}};
  assign hi_mask  = ctl.last ? ~({WORD_BITS{1'b1}} << ctl.limit) : {WORD_BITS{1'b1}};
  assign masked   = data & lo_mask & hi_mask;
  // two's complement trick leaves only the lowest set bit
  assign isolated = masked & (~masked + {{(WORD_BITS-1){1'b0}}, 1'b1});

  always_comb begin
    lane = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (isolated[i]) begin
        lane = lane | bfns_pkg::LANE_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= ctl.valid;
    end
    res.hit <= |masked;
    res.pos <= ctl.base + bfns_pkg::CNT_W'(lane);
  end

endmodule

@@ rtl/bitmap_find_next_set_bit.sv @@
// ----------------------------------------------------------------------------
// bitmap_find_next_set_bit
// Bitmap of WORDS words held in a RAM; finds the lowest set bit in
// [start_bit, search_size), scanning one word per cycle.
//
//   channel | dir | beat contents
//   --------+-----+-------------------------------------------------------
//   req     | in  | operation, word_index, word_data, start_bit, search_size
//   rsp     | out | bit_position, found (one beat per search, none per write)
//
// A write goes into the RAM as its request beat is taken. A search passes
// the states S_DIV, S_BASE, S_SCAN and S_FINISH, which raises rsp.valid; in
// S_SCAN each word read goes through the RAM read register and the scan result
// register; the single RAM read port sets one word per cycle. A start at or
// beyond the size skips S_BASE and S_SCAN, and a start past the last stored
// word reads no word. After reset a clearing pass writes zero to every word
// with req.ready low. req is taken in idle even while a result waits on rsp;
// a stalled rsp holds the next search in its final state.
module bitmap_find_next_set_bit #(
  parameter int WORD_BITS = 64,
  parameter int WORDS     = 64
) (
  input logic        clk,
  input logic        rst,
  bfns_in_if.sink    req,
  bfns_out_if.source rsp
);

  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W  = bfns_pkg::CNT_W;
  localparam int POS_W  = bfns_pkg::POS_W;
  localparam int LANE_W = bfns_pkg::LANE_W;
  // exact reciprocal for start_bit / WORD_BITS over all 13-bit operands
  localparam int SH     = POS_W + $clog2(WORD_BITS);
  localparam int RECIP  = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_BASE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t              state;
  logic [AW-1:0]       clr_addr;
  logic [POS_W-1:0]    start_r;
  logic [POS_W-1:0]    size_r;
  logic [CNT_W-1:0]    wq;
  logic [CNT_W-1:0]    base;
  logic [LANE_W-1:0]   offset;
  logic                first_pend;
  logic [POS_W-1:0]    res_pos;
  logic                res_found;
  logic                out_valid;
  logic [POS_W-1:0]    out_pos;
  logic                out_found;
  bfns_pkg::scan_ctl_t p1;
  bfns_pkg::scan_ctl_t p1_next;
  bfns_pkg::scan_res_t scan_res;

  logic                accept;
  logic                wr_ok;
  logic [31:0]         widx32;
  logic [31:0]         prod;
  logic [31:0]         base_mul;
  logic [CNT_W-1:0]    rem;
  logic                issue_more;
  logic                issue;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign widx32 = 32'(req.word_index);
  assign wr_ok  = accept && (req.operation == bfns_pkg::OP_WRITE) && (widx32 < WORDS);

  assign ram_we    = (state == S_CLEAR) || wr_ok;
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : widx32[AW-1:0];
  assign ram_wdata = (state == S_CLEAR) ? '0 : req.word_data[WORD_BITS-1:0];

  assign prod     = 32'(start_r) * 32'(RECIP);
  assign base_mul = 32'(wq) * 32'(WORD_BITS);

  // words past the end of the bitmap are not read, so the scan stops there
  assign issue_more = (base < {1'b0, size_r}) && (wq < CNT_W'(WORDS));
  assign issue      = (state == S_SCAN) && issue_more;
  assign rem        = {1'b0, size_r} - base;

  always_comb begin
    p1_next        = '0;
    p1_next.valid  = issue;
    p1_next.base   = base;
    p1_next.first  = first_pend;
    p1_next.offset = offset;
    p1_next.last   = rem < CNT_W'(WORD_BITS);
    p1_next.limit  = LANE_W'(rem);
  end

  bfns_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (wq[AW-1:0]),
    .rdata (ram_rdata)
  );

  bfns_word_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .data (ram_rdata),
    .ctl  (p1),
    .res  (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      p1        <= '0;
    end else begin
      p1 <= p1_next;
      if (rsp.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == WORDS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && req.operation == bfns_pkg::OP_SEARCH) begin
            start_r <= req.start_bit;
            size_r  <= req.search_size;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (start_r >= size_r) begin
            res_pos   <= size_r;
            res_found <= 1'b0;
            state     <= S_FINISH;
          end else begin
            wq    <= CNT_W'(prod >> SH);
            state <= S_BASE;
          end
        end
        S_BASE: begin
          base       <= CNT_W'(base_mul);
          offset     <= LANE_W'({1'b0, start_r} - CNT_W'(base_mul));
          first_pend <= 1'b1;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          if (issue) begin
            wq         <= wq + CNT_W'(1);
            base       <= base + CNT_W'(WORD_BITS);
            first_pend <= 1'b0;
          end
          if (scan_res.valid && scan_res.hit) begin
            res_pos   <= POS_W'(scan_res.pos);
            res_found <= 1'b1;
            state     <= S_FINISH;
          end else if (!issue_more && !p1.valid && !scan_res.valid) begin
            res_pos   <= size_r;
            res_found <= 1'b0;
            state     <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_pos   <= res_pos;
            out_found <= res_found;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.bit_position = out_pos;
  assign rsp.found        = out_found;

  // no word read may still be in flight when a new request can be taken
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !p1.valid)
    else $error("scan read still in flight in idle");

  // only the first word of a search is masked below the start offset
  assert property (@(posedge clk) disable iff (rst)
    (p1.valid && p1.first) |=> !(p1.valid && p1.first))
    else $error("start mask applied to more than one word");

  // a hit taken from the scan lies inside the search window
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_res.valid && scan_res.hit)
      |-> (scan_res.pos < {1'b0, size_r}))
    else $error("hit position at or beyond search size");

  // reads stay inside the stored bitmap
  assert property (@(posedge clk) disable iff (rst)
    issue |-> (wq < CNT_W'(WORDS)))
    else $error("read issued past the last bitmap word");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the bitmap next-set-bit search. A shadow copy of the bitmap
// is kept and updated with every accepted word write; each accepted search
// is resolved against it and the position and found flag are queued. Every
// result beat is checked against the oldest queued entry. Directed tests
// cover an empty bitmap, word edges, searches past the bitmap end and empty
// ranges. Random tests follow, with random gaps on both channels and one
// stretch with none.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WORD_BITS    = 64;
  localparam int WORDS        = 64;
  localparam int MAP_BITS     = WORD_BITS * WORDS;
  localparam int SCAN_CYCLES  = WORDS + 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam int POS_W        = bfns_pkg::POS_W;
  localparam int IDX_W        = bfns_pkg::IDX_W;
  localparam int DATA_W       = bfns_pkg::DATA_W;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             found;
  } bit_hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bfns_in_if  req_if ();
  bfns_out_if rsp_if ();

  bitmap_find_next_set_bit #(
    .WORD_BITS (WORD_BITS),
    .WORDS     (WORDS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  logic [WORD_BITS-1:0] shadow_bitmap [WORDS];
  bit_hit_t             awaited_hits[$];
  int                   mismatches = 0;
  int                   cycles = 0;
  bit                   eager = 1'b0;  // no gaps on either channel

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               awaited_hits.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // lowest set bit in [from, bound); bits past the bitmap read as zero
  function automatic bit_hit_t next_set_bit(input logic [POS_W-1:0] from,
                                            input logic [POS_W-1:0] bound);
    bit_hit_t r;
    int       b;
    r.pos   = bound;
    r.found = 1'b0;
    for (b = int'(from); b < int'(bound) && !r.found; b++) begin
      if (b < MAP_BITS && shadow_bitmap[b / WORD_BITS][b % WORD_BITS]) begin
        r.pos   = POS_W'(b);
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic int draw_gap();
    return eager ? 0 : int'($urandom_range(0, 10));
  endfunction

  // sends one beat and waits for it to be taken, then updates the shadow or queues the result
  task automatic issue_request(input bfns_pkg::op_t op, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] data,
                               input logic [POS_W-1:0] start,
                               input logic [POS_W-1:0] size);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.word_index  <= idx;
    req_if.word_data   <= data;
    req_if.start_bit   <= start;
    req_if.search_size <= size;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    if (op == bfns_pkg::OP_WRITE) begin
      if (int'(idx) < WORDS) shadow_bitmap[idx] = data[WORD_BITS-1:0];
    end else begin
      awaited_hits = {awaited_hits, next_set_bit(start, size)};
    end
  endtask

  task automatic write_word(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    issue_request(bfns_pkg::OP_WRITE, idx, data, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic search(input logic [POS_W-1:0] start, input logic [POS_W-1:0] size);
    issue_request(bfns_pkg::OP_SEARCH, IDX_W'($urandom), {$urandom, $urandom}, start,
                  size);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (awaited_hits.size() != 0);
  endtask

  // result beats, taken against the oldest outstanding search
  always @(posedge clk) begin
    bit_hit_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (awaited_hits.size() == 0) begin
        report_mismatch($sformatf("unexpected beat pos=%0d found=%0b",
                                  rsp_if.bit_position, rsp_if.found));
      end else begin
        want = awaited_hits.pop_front();
        if (rsp_if.bit_position !== want.pos)
          report_mismatch($sformatf("bit_position %0d, want %0d",
                                    rsp_if.bit_position, want.pos));
        if (rsp_if.found !== want.found)
          report_mismatch($sformatf("found %0b, want %0b (pos %0d)",
                                    rsp_if.found, want.found, want.pos));
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: return '0;
      8, 9, 10, 11, 12:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      13, 14, 15:             return {$urandom, $urandom} & {$urandom, $urandom}
                                     & {$urandom, $urandom};
      16, 17, 18:             return {$urandom, $urandom};
      default:                return '1;
    endcase
  endfunction

  task automatic random_search();
    int start;
    int size;
    case ($urandom_range(0, 9))
      0: begin
        start = $urandom_range(0, 8191);
        size  = $urandom_range(0, 8191);
      end
      1: begin
        start = $urandom_range(0, MAP_BITS);
        size  = start - int'($urandom_range(0, 3));
        if (size < 0) size = 0;
      end
      2: begin
        start = $urandom_range(0, MAP_BITS - 1);
        size  = MAP_BITS;
      end
      default: begin
        start = $urandom_range(0, MAP_BITS - 1);
        size  = $urandom_range(start, MAP_BITS + 100);
      end
    endcase
    search(POS_W'(start), POS_W'(size));
  endtask

  task automatic random_items(input int count, input int write_pct);
    int i;
    for (i = 0; i < count; i++) begin
      if (int'($urandom_range(0, 99)) < write_pct)
        write_word(IDX_W'($urandom_range(0, WORDS - 1)), random_word());
      else
        random_search();
    end
  endtask

  task automatic test_empty_bitmap();
    search(13'd0, 13'd4096);
    search(13'd0, 13'd0);
    search(13'd100, 13'd3);
    search(13'd8191, 13'd8191);
    search(13'd0, 13'd8191);
    search(13'd4096, 13'd8191);
  endtask

  task automatic test_word_edges();
    write_word(6'd0, 64'd1);
    write_word(6'd63, 64'h8000_0000_0000_0000);
    write_word(6'd10, '1);
    write_word(6'd20, 64'd1 << 40);
    search(13'd0, 13'd4096);
    search(13'd1, 13'd4096);
    search(13'd641, 13'd700);
    search(13'd704, 13'd1321);    // size one past the set bit
    search(13'd704, 13'd1320);    // size masks the set bit away
    search(13'd641, 13'd641);
    search(13'd3000, 13'd4096);
    search(13'd4095, 13'd8191);
    write_word(6'd10, 64'd0);
    write_word(6'd0, 64'd0);
    search(13'd1, 13'd4096);
    search(13'd1321, 13'd8191);
  endtask

  task automatic test_random_mixed();
    random_items(450, 35);
  endtask

  task automatic test_back_to_back();
    eager = 1'b1;
    random_items(150, 35);
    drain_results();
    eager = 1'b0;
  endtask

  // mostly clear words so that scans run long
  task automatic test_sparse_long_scans();
    int i;
    for (i = 0; i < WORDS; i++) write_word(IDX_W'(i), '0);
    for (i = 0; i < 190; i++) begin
      if ($urandom_range(0, 99) < 10)
        write_word(IDX_W'($urandom_range(0, WORDS - 1)),
                   $urandom_range(0, 1) ? DATA_W'(1) << $urandom_range(0, DATA_W - 1)
                                        : DATA_W'(0));
      else
        random_search();
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < WORDS; i++) shadow_bitmap[i] = '0;
    req_if.valid       <= 1'b0;
    req_if.operation   <= bfns_pkg::OP_WRITE;
    req_if.word_index  <= '0;
    req_if.word_data   <= '0;
    req_if.start_bit   <= '0;
    req_if.search_size <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_bitmap();
    test_word_edges();
    drain_results();
    test_random_mixed();
    drain_results();
    test_back_to_back();
    test_sparse_long_scans();
    drain_results();

    repeat (SCAN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
